FILE: design/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam logic [7:0] PLAIN_ATTR   = 8'h07;
  localparam logic [7:0] ESC_BYTE     = 8'h26;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] LOWER_A      = 8'h61;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] HIGH_BYTE    = 8'h80;
  localparam logic [7:0] NUL_BYTE     = 8'h00;

  localparam logic [6:0] COLUMNS_RESET = 7'd80;

  localparam logic MODE_FEED = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [15:0] BLANK_CELL = {PLAIN_ATTR, NUL_BYTE};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK
  } tcw_state_t;

  // color letter or digit after the escape byte
  function automatic logic [7:0] color_of(input logic [7:0] b);
    logic [7:0] res;
    if (b >= HIGH_BYTE) begin
      res = PLAIN_ATTR;
    end else if (b >= LOWER_A) begin
      res = b - LOWER_A + 8'd10;
    end else if (b >= DIGIT_ZERO) begin
      res = b - DIGIT_ZERO;
    end else begin
      res = PLAIN_ATTR;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/tcw_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  data_byte;
  logic [10:0] cell_index;

  modport source (output valid, mode, data_byte, cell_index, input ready);
  modport sink (input valid, mode, data_byte, cell_index, output ready);
endinterface

interface tcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] current_attr;
  logic       scrolled;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, current_attr,
                  scrolled, input ready);
  modport sink (input valid, cell_char, cell_attr, cursor_col, cursor_row, current_attr,
                scrolled, output ready);
endinterface

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] columns;

  modport source (output valid, columns, input ready);
  modport sink (input valid, columns, output ready);
endinterface

`default_nettype wire

FILE: design/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// text console writer: character-cell screen with cursor and current attribute
// - in_ch takes one word per item: mode 0 feeds one message byte, mode 1 reads
//   the cell at cell_index; every item gives exactly one word on out_ch
// - cfg_ch writes the column count; write it only while the block is idle
// - plain bytes, escapes, zero bytes and newlines that need no scroll: result word is
//   registered in the cycle after accept, a new item can be taken every cycle unless out stalls
// - cell read: result passes the registered read of the store, then the output register
// - a scroll copies (SCREEN_ROWS-1)*columns cells through the single store,
//   one cell per cycle, then blanks one row, one cell per cycle; nothing else
//   is accepted until the item's result is registered
// - reset: cursor 0/0, attribute 7, columns 80, then a clearing pass writes
//   zero to all MAX_COLUMNS*SCREEN_ROWS cells;
//   in_ch.ready stays low during that pass, cfg writes are taken as ever
// - out stall: the result waits in the output register; the next item is
//   taken in the cycle that register drains, so no result is ever dropped
module text_console_writer #(
  parameter int MAX_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  localparam int CELL_COUNT = MAX_COLUMNS * SCREEN_ROWS;
  localparam int AW         = $clog2(CELL_COUNT);

  // sequencer and architectural state
  tcw_pkg::tcw_state_t state_r, state_nxt;
  logic [6:0]  columns_r;
  logic [6:0]  cur_col_r, cur_col_nxt;
  logic [4:0]  cur_row_r, cur_row_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic        esc_r, esc_nxt;

  // shared sweep counter for clear, copy and blank
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          idx_ok_r, idx_ok_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] o_char_r, o_char_nxt;
  logic [7:0] o_attr_r, o_attr_nxt;
  logic [6:0] o_col_r, o_col_nxt;
  logic [4:0] o_row_r, o_row_nxt;
  logic [7:0] o_cur_attr_r, o_cur_attr_nxt;
  logic       o_scr_r, o_scr_nxt;

  // store port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // decode
  logic        accept;
  logic        need_scroll;
  logic        last_clear, last_copy, last_blank;
  logic [6:0]  cols;
  logic [12:0] cur_addr, keep_cells;
  logic [5:0]  row_inc;
  logic [7:0]  col_inc;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // live column count: 0 acts as 1, above the maximum clamps
  always_comb begin
    if (columns_r == 7'd0) begin
      cols = 7'd1;
    end else if (32'(columns_r) > MAX_COLUMNS) begin
      cols = 7'(MAX_COLUMNS);
    end else begin
      cols = columns_r;
    end
  end

  assign accept     = in_ch.valid && in_ch.ready;
  assign cur_addr   = 13'(cur_row_r) * 13'(cols) + 13'(cur_col_r);
  assign keep_cells = 13'(cols) * 13'(SCREEN_ROWS - 1);
  assign row_inc    = {1'b0, cur_row_r} + 6'd1;
  assign col_inc    = {1'b0, cur_col_r} + 8'd1;
  assign last_clear = (13'(cnt_r) == 13'(CELL_COUNT - 1));
  assign last_copy  = (13'(cnt_r) == keep_cells - 13'd1);
  assign last_blank = (13'(cnt_r) == 13'(cols) - 13'd1);

  assign in_ch.ready  = (state_r == tcw_pkg::ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cell_char    = o_char_r;
  assign out_ch.cell_attr    = o_attr_r;
  assign out_ch.cursor_col   = o_col_r;
  assign out_ch.cursor_row   = o_row_r;
  assign out_ch.current_attr = o_cur_attr_r;
  assign out_ch.scrolled     = o_scr_r;

  // byte interpretation: cursor, attribute and escape updates
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    attr_nxt    = attr_r;
    esc_nxt     = esc_r;
    need_scroll = 1'b0;
    if (accept && in_ch.mode == tcw_pkg::MODE_FEED) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if (in_ch.data_byte != tcw_pkg::NUL_BYTE) begin
          attr_nxt = tcw_pkg::color_of(in_ch.data_byte);
        end
      end else if (in_ch.data_byte == tcw_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else if (in_ch.data_byte != tcw_pkg::NUL_BYTE) begin
        if (in_ch.data_byte == tcw_pkg::NEWLINE_BYTE) begin
          cur_col_nxt = 7'd0;
          attr_nxt    = tcw_pkg::PLAIN_ATTR;
          need_scroll = (row_inc >= 6'(SCREEN_ROWS));
          cur_row_nxt = need_scroll ? 5'(SCREEN_ROWS - 1) : row_inc[4:0];
        end else if (col_inc >= {1'b0, cols}) begin
          // wrap to the next row
          cur_col_nxt = 7'd0;
          need_scroll = (row_inc >= 6'(SCREEN_ROWS));
          cur_row_nxt = need_scroll ? 5'(SCREEN_ROWS - 1) : row_inc[4:0];
        end else begin
          cur_col_nxt = col_inc[6:0];
        end
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        if (last_clear) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == tcw_pkg::MODE_READ) begin
            state_nxt = tcw_pkg::ST_READ;
          end else if (need_scroll) begin
            state_nxt = tcw_pkg::ST_COPY;
          end
        end
      end
      tcw_pkg::ST_READ:  state_nxt = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_COPY: begin
        if (last_copy) begin
          state_nxt = tcw_pkg::ST_DRAIN;
        end
      end
      tcw_pkg::ST_DRAIN: state_nxt = tcw_pkg::ST_BLANK;
      tcw_pkg::ST_BLANK: begin
        if (last_blank) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  // store port, sweep counter and output register
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = cur_addr[AW-1:0];
    ram_wdata      = {attr_r, in_ch.data_byte};
    ram_raddr      = AW'(in_ch.cell_index);
    cnt_nxt        = cnt_r;
    dst_nxt        = dst_r;
    idx_ok_nxt     = idx_ok_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_char_nxt     = o_char_r;
    o_attr_nxt     = o_attr_r;
    o_col_nxt      = o_col_r;
    o_row_nxt      = o_row_r;
    o_cur_attr_nxt = o_cur_attr_r;
    o_scr_nxt      = o_scr_r;
    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = 16'h0000;
        cnt_nxt   = cnt_r + AW'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == tcw_pkg::MODE_READ) begin
            idx_ok_nxt = (32'(in_ch.cell_index) < CELL_COUNT);
          end else begin
            // printable byte goes to the cell under the cursor
            ram_we = !esc_r && in_ch.data_byte != tcw_pkg::ESC_BYTE
                     && in_ch.data_byte != tcw_pkg::NUL_BYTE
                     && in_ch.data_byte != tcw_pkg::NEWLINE_BYTE;
            cnt_nxt = '0;
            if (!need_scroll) begin
              out_valid_nxt  = 1'b1;
              o_char_nxt     = 8'd0;
              o_attr_nxt     = 8'd0;
              o_col_nxt      = cur_col_nxt;
              o_row_nxt      = cur_row_nxt;
              o_cur_attr_nxt = attr_nxt;
              o_scr_nxt      = 1'b0;
            end
          end
        end
      end
      tcw_pkg::ST_READ: begin
        out_valid_nxt  = 1'b1;
        o_char_nxt     = idx_ok_r ? ram_rdata[7:0] : 8'd0;
        o_attr_nxt     = idx_ok_r ? ram_rdata[15:8] : 8'd0;
        o_col_nxt      = cur_col_r;
        o_row_nxt      = cur_row_r;
        o_cur_attr_nxt = attr_r;
        o_scr_nxt      = 1'b0;
      end
      tcw_pkg::ST_COPY: begin
        // read one row ahead, write the cell read last cycle
        ram_raddr = AW'(13'(cnt_r) + 13'(cols));
        ram_we    = (cnt_r != '0);
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        dst_nxt   = cnt_r;
        cnt_nxt   = cnt_r + AW'(1);
      end
      tcw_pkg::ST_DRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        cnt_nxt   = '0;
      end
      tcw_pkg::ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(keep_cells + 13'(cnt_r));
        ram_wdata = tcw_pkg::BLANK_CELL;
        cnt_nxt   = cnt_r + AW'(1);
        if (last_blank) begin
          out_valid_nxt  = 1'b1;
          o_char_nxt     = 8'd0;
          o_attr_nxt     = 8'd0;
          o_col_nxt      = cur_col_r;
          o_row_nxt      = cur_row_r;
          o_cur_attr_nxt = attr_r;
          o_scr_nxt      = 1'b1;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_CLEAR;
      columns_r   <= tcw_pkg::COLUMNS_RESET;
      cur_col_r   <= 7'd0;
      cur_row_r   <= 5'd0;
      attr_r      <= tcw_pkg::PLAIN_ATTR;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      attr_r      <= attr_nxt;
      esc_r       <= esc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        columns_r <= cfg_ch.columns;
      end
    end
  end

  always_ff @(posedge clk) begin
    dst_r        <= dst_nxt;
    idx_ok_r     <= idx_ok_nxt;
    o_char_r     <= o_char_nxt;
    o_attr_r     <= o_attr_nxt;
    o_col_r      <= o_col_nxt;
    o_row_r      <= o_row_nxt;
    o_cur_attr_r <= o_cur_attr_nxt;
    o_scr_r      <= o_scr_nxt;
  end

endmodule

`default_nettype wire
